// ===== src/ipv4_forwarding_decision_macros.svh =====
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision_macros
// assertion macros shared by the forwarding decision rtl
// ----------------------------------------------------------------------------
`ifndef IPV4_FORWARDING_DECISION_MACROS_SVH
`define IPV4_FORWARDING_DECISION_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication under reset
`define IFD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication under reset
`define IFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IFD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define IFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== src/ifd_pkg.sv =====
// ----------------------------------------------------------------------------
// ifd_pkg
// types and constants of the ipv4 forwarding decision block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ifd_pkg;

  // table sizes
  localparam int ROUTES = 16;
  localparam int PORTS  = 4;
  localparam int RIDX_W = (ROUTES > 1) ? $clog2(ROUTES) : 1;

  // protocol and icmp constants
  localparam logic [7:0] PROTO_TCP          = 8'd6;
  localparam logic [7:0] PROTO_UDP          = 8'd17;
  localparam logic [7:0] PROTO_ICMP         = 8'd1;
  localparam logic [7:0] ICMP_ECHO_REQ      = 8'd8;
  localparam logic [7:0] ICMP_ECHO_RPL      = 8'd0;
  localparam logic [7:0] ICMP_UNREACH       = 8'd3;
  localparam logic [7:0] ICMP_TIME_EXC      = 8'd11;
  localparam logic [7:0] CODE_PORT_UNREACH  = 8'd3;
  localparam logic [7:0] CODE_PROTO_UNREACH = 8'd2;
  localparam logic [7:0] CODE_HOST_UNREACH  = 8'd1;
  localparam logic [7:0] CODE_NET_UNREACH   = 8'd0;
  localparam logic [7:0] CODE_NONE          = 8'd0;
  localparam logic [7:0] TTL_MINIMUM        = 8'd1;

  // item kinds
  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_ROUTE_WR = 2'd1,
    KIND_PORT_WR  = 2'd2
  } kind_e;

  // result actions
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_FORWARD = 2'd1,
    ACT_ICMP    = 2'd2
  } action_e;

  // configuration registers
  typedef enum logic {
    REG_ROUTE_COUNT = 1'b0,
    REG_PORT_COUNT  = 1'b1
  } cfg_reg_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PORT,
    ST_SEARCH,
    ST_DONE
  } state_e;

  // input word
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  in_port;
    logic [3:0]  entry_index;
    logic [31:0] dest_addr;
    logic [7:0]  protocol;
    logic [7:0]  hop_limit;
    logic [7:0]  echo_kind;
    logic [31:0] new_prefix;
    logic [31:0] new_mask;
    logic [31:0] new_gateway;
    logic [1:0]  new_route_port;
    logic [31:0] new_port_addr;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  reply_type;
    logic [7:0]  reply_code;
    logic [1:0]  out_port;
    logic [31:0] next_hop;
    logic [7:0]  out_hop_limit;
  } out_word_t;

  // route write into the cell row
  typedef struct packed {
    logic        en;
    logic [3:0]  index;
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [1:0]  port;
  } route_wr_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic [31:0] dst;
    logic        found;
    logic [31:0] best_mask;
    logic [31:0] gateway;
    logic [1:0]  port;
  } srch_t;

  // port address check result
  typedef struct packed {
    logic local_hit;
    logic other_hit;
  } port_hit_t;

endpackage

// ===== src/ipv4_forwarding_decision.sv =====
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision
// ipv4 forwarding decision with a chained longest prefix match route table
// ----------------------------------------------------------------------------
//  channel  direction  handshake             word
//  in       input      in_valid_i/in_stall_o  in_word_i   (header or table write)
//  out      output     out_valid_o/out_stall_i out_word_o (decision)
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  one word in flight at a time; in_stall_o is high until the controller is idle
//  writes and port-level answers go from the accepted word register to the output register
//  a routed header sends a token down the cell row, one cell per cycle, so the
//  row length sets the latency
//  a stalled output holds its word while the next word is already accepted
//  reset clears counts and control; table contents are undefined until written
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ipv4_forwarding_decision_macros.svh"

module ipv4_forwarding_decision (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ifd_pkg::in_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ifd_pkg::out_word_t out_word_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [4:0]        cfg_data_i
);
  import ifd_pkg::*;

  state_e    state_q, state_d;
  in_word_t  hdr_q;
  srch_t     fin_q;
  logic [4:0] route_count_q;
  logic [2:0] port_count_q;
  logic      out_valid_q;
  out_word_t out_q;
  out_word_t res;
  logic      out_load;
  logic      out_free;
  logic      in_accept;
  logic      launch;
  route_wr_t rwr;
  port_hit_t phit;
  logic      tok_valid [ROUTES+1];
  srch_t     tok       [ROUTES+1];
  logic [ROUTES:0] tok_vec;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free = !out_valid_q || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_count_q <= '0;
      port_count_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROUTE_COUNT: route_count_q <= cfg_data_i;
        REG_PORT_COUNT:  port_count_q  <= cfg_data_i[2:0];
        default:         route_count_q <= route_count_q;
      endcase
    end
  end

  // accepted word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hdr_q <= in_word_i;
    end
  end

  // route writes into the row
  always_comb begin
    rwr.en      = in_accept && (in_word_i.kind == KIND_ROUTE_WR);
    rwr.index   = in_word_i.entry_index;
    rwr.prefix  = in_word_i.new_prefix;
    rwr.mask    = in_word_i.new_mask;
    rwr.gateway = in_word_i.new_gateway;
    rwr.port    = in_word_i.new_route_port;
  end

  ifd_port_table u_port_table (
    .clk_i        (clk_i),
    .wr_en_i      (in_accept && (in_word_i.kind == KIND_PORT_WR)),
    .wr_index_i   (in_word_i.entry_index),
    .wr_addr_i    (in_word_i.new_port_addr),
    .port_count_i (port_count_q),
    .dst_i        (hdr_q.dest_addr),
    .in_port_i    (hdr_q.in_port),
    .hit_o        (phit)
  );

  // token launch into the first cell
  assign tok_valid[0] = launch;
  assign tok[0]       = '{dst: hdr_q.dest_addr, default: '0};

  // row of route cells
  for (genvar g = 0; g < ROUTES; g++) begin : g_cell
    ifd_route_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cell_idx_i    (RIDX_W'(g)),
      .route_count_i (route_count_q),
      .wr_i          (rwr),
      .tok_valid_i   (tok_valid[g]),
      .tok_i         (tok[g]),
      .tok_valid_o   (tok_valid[g+1]),
      .tok_o         (tok[g+1])
    );
  end

  for (genvar g = 0; g <= ROUTES; g++) begin : g_vec
    assign tok_vec[g] = tok_valid[g];
  end

  // final token of the search
  always_ff @(posedge clk_i) begin
    if (tok_valid[ROUTES]) begin
      fin_q <= tok[ROUTES];
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and result word
  always_comb begin
    state_d  = state_q;
    res      = '0;
    out_load = 1'b0;
    launch   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_PORT;
        end
      end
      ST_PORT: begin
        if ((hdr_q.kind == KIND_HEADER) && !phit.local_hit && !phit.other_hit) begin
          launch  = 1'b1;
          state_d = ST_SEARCH;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (hdr_q.kind == KIND_HEADER) begin
            res.action = ACT_ICMP;
            if (phit.local_hit) begin
              // packet for the arrival port
              priority if ((hdr_q.protocol == PROTO_TCP) ||
                           (hdr_q.protocol == PROTO_UDP)) begin
                res.reply_type = ICMP_UNREACH;
                res.reply_code = CODE_PORT_UNREACH;
              end else if (hdr_q.hop_limit == TTL_MINIMUM) begin
                res.reply_type = ICMP_TIME_EXC;
                res.reply_code = CODE_NONE;
              end else if (hdr_q.protocol == PROTO_ICMP) begin
                if (hdr_q.echo_kind == ICMP_ECHO_REQ) begin
                  res.reply_type = ICMP_ECHO_RPL;
                  res.reply_code = CODE_NONE;
                end else begin
                  res.action = ACT_NONE;
                end
              end else begin
                res.reply_type = ICMP_UNREACH;
                res.reply_code = CODE_PROTO_UNREACH;
              end
            end else begin
              // packet for another router port
              res.reply_type = ICMP_UNREACH;
              res.reply_code = CODE_HOST_UNREACH;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (tok_valid[ROUTES]) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          priority if (!fin_q.found) begin
            res.action     = ACT_ICMP;
            res.reply_type = ICMP_UNREACH;
            res.reply_code = CODE_NET_UNREACH;
          end else if (hdr_q.hop_limit <= TTL_MINIMUM) begin
            res.action     = ACT_ICMP;
            res.reply_type = ICMP_TIME_EXC;
            res.reply_code = CODE_NONE;
          end else begin
            res.action        = ACT_FORWARD;
            res.out_port      = fin_q.port;
            res.next_hop      = (fin_q.gateway != '0) ? fin_q.gateway : hdr_q.dest_addr;
            res.out_hop_limit = 8'(hdr_q.hop_limit - 8'd1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // checks
  `IFD_ASSERT_IMPL(a_one_token, clk_i, rst_ni, 1'b1, $onehot0(tok_vec), "more than one token in the row")
  `IFD_ASSERT_IMPL(a_token_end, clk_i, rst_ni, tok_valid[ROUTES], state_q == ST_SEARCH, "token arrived outside search")
  `IFD_ASSERT_NEXT(a_accept_port, clk_i, rst_ni, in_accept, state_q == ST_PORT, "accepted word not taken to port check")
  `IFD_ASSERT_IMPL(a_fwd_ttl, clk_i, rst_ni, out_valid_q && (out_q.action == ACT_FORWARD), out_q.out_hop_limit != 8'd0, "forwarded word with zero hop limit")

endmodule

// ===== src/ifd_route_cell.sv =====
// ----------------------------------------------------------------------------
// ifd_route_cell
// one route entry plus one stage of the longest prefix match chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifd_route_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ifd_pkg::RIDX_W-1:0] cell_idx_i,
  input  logic [4:0]                route_count_i,
  input  ifd_pkg::route_wr_t        wr_i,
  input  logic                      tok_valid_i,
  input  ifd_pkg::srch_t            tok_i,
  output logic                      tok_valid_o,
  output ifd_pkg::srch_t            tok_o
);
  import ifd_pkg::*;

  logic [31:0] prefix_q;
  logic [31:0] mask_q;
  logic [31:0] gateway_q;
  logic [1:0]  port_q;
  logic        tok_valid_q;
  srch_t       tok_q;
  srch_t       tok_d;
  logic        in_range;
  logic        hit;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (32'(wr_i.index) == 32'(cell_idx_i))) begin
      prefix_q  <= wr_i.prefix;
      mask_q    <= wr_i.mask;
      gateway_q <= wr_i.gateway;
      port_q    <= wr_i.port;
    end
  end

  // compare against this entry, later equal mask wins
  always_comb begin
    in_range = 32'(cell_idx_i) < 32'(route_count_i);
    hit      = in_range && ((mask_q & tok_i.dst) == prefix_q) && (mask_q >= tok_i.best_mask);
    tok_d    = tok_i;
    if (hit) begin
      tok_d.found     = 1'b1;
      tok_d.best_mask = mask_q;
      tok_d.gateway   = gateway_q;
      tok_d.port      = port_q;
    end
  end

  // token valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
    end
  end

  // token payload
  always_ff @(posedge clk_i) begin
    if (tok_valid_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

// ===== src/ifd_port_table.sv =====
// ----------------------------------------------------------------------------
// ifd_port_table
// router port addresses and the local / other port address checks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifd_port_table (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [3:0]         wr_index_i,
  input  logic [31:0]        wr_addr_i,
  input  logic [2:0]         port_count_i,
  input  logic [31:0]        dst_i,
  input  logic [1:0]         in_port_i,
  output ifd_pkg::port_hit_t hit_o
);
  import ifd_pkg::*;

  logic [31:0] addr_q [PORTS];
  logic [PORTS-1:0] match;
  logic [PORTS-1:0] local_match;

  // address storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PORTS; i++) begin
      if (wr_en_i && (32'(wr_index_i) == 32'(i))) begin
        addr_q[i] <= wr_addr_i;
      end
    end
  end

  // compare destination with every valid port
  always_comb begin
    for (int i = 0; i < PORTS; i++) begin
      match[i]       = (32'(i) < 32'(port_count_i)) && (dst_i == addr_q[i]);
      local_match[i] = match[i] && (32'(in_port_i) == 32'(i));
    end
    hit_o.local_hit = |local_match;
    hit_o.other_hit = |match;
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ipv4 forwarding decision block: a queue-fed
// driver offers table writes and packet headers, a monitor predicts every
// decision from a shadow copy of the tables and counts, and compares each
// result word field by field under random gaps, stalls and a long hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ifd_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 230;
  localparam int PRINT_LIMIT  = 50;

  // kind code that the block answers with no action, and a protocol it does not serve
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic [7:0] PROTO_GRE    = 8'd47;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_index_i = 1'b0;
  logic [4:0] cfg_data_i = '0;

  ipv4_forwarding_decision dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // shadow tables and counts of the block
  logic [31:0] rt_prefix  [ROUTES];
  logic [31:0] rt_mask    [ROUTES];
  logic [31:0] rt_gateway [ROUTES];
  logic [1:0]  rt_port    [ROUTES];
  logic [31:0] port_addr  [PORTS];
  logic [4:0]  route_cnt = '0;
  logic [2:0]  port_cnt  = '0;

  // generator view of the tables, updated as words are queued
  logic [31:0] gen_prefix    [ROUTES];
  logic [31:0] gen_mask      [ROUTES];
  logic [31:0] gen_port_addr [PORTS];

  in_word_t  word_q[$];
  out_word_t decision_q[$];
  out_word_t want_word;

  int   errors        = 0;
  int   cycles        = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   hold_reqs     = 0;
  int   hold_seen     = 0;
  int   hold_left     = 0;
  logic in_took       = 1'b0;

  int route_set [PHASES] = '{16, 31, 5, 16, 0, 11, 16, 1};
  int port_set  [PHASES] = '{4, 7, 2, 0, 13, 3, 4, 1};

  function automatic out_word_t icmp_word(logic [7:0] icmp_type, logic [7:0] icmp_code);
    out_word_t r;
    r = '0;
    r.action     = ACT_ICMP;
    r.reply_type = icmp_type;
    r.reply_code = icmp_code;
    return r;
  endfunction

  // decision for one word, applying table writes to the shadow copy
  function automatic out_word_t decide_forwarding(in_word_t w);
    out_word_t   r;
    int          nports;
    int          nroutes;
    int          best;
    logic        found;
    logic [31:0] best_mask;
    r         = '0;
    nports    = (port_cnt > PORTS) ? PORTS : port_cnt;
    nroutes   = (route_cnt > ROUTES) ? ROUTES : route_cnt;
    best      = 0;
    found     = 1'b0;
    best_mask = '0;
    case (w.kind)
      KIND_ROUTE_WR: begin
        if (w.entry_index < ROUTES) begin
          rt_prefix[w.entry_index]  = w.new_prefix;
          rt_mask[w.entry_index]    = w.new_mask;
          rt_gateway[w.entry_index] = w.new_gateway;
          rt_port[w.entry_index]    = w.new_route_port;
        end
      end
      KIND_PORT_WR: begin
        if (w.entry_index < PORTS) port_addr[w.entry_index] = w.new_port_addr;
      end
      KIND_HEADER: begin
        // packet for the arrival port itself
        if (w.in_port < nports && w.dest_addr == port_addr[w.in_port]) begin
          if (w.protocol == PROTO_TCP || w.protocol == PROTO_UDP)
            return icmp_word(ICMP_UNREACH, CODE_PORT_UNREACH);
          if (w.hop_limit == TTL_MINIMUM)
            return icmp_word(ICMP_TIME_EXC, CODE_NONE);
          if (w.protocol == PROTO_ICMP) begin
            if (w.echo_kind == ICMP_ECHO_REQ)
              return icmp_word(ICMP_ECHO_RPL, CODE_NONE);
            return r;
          end
          return icmp_word(ICMP_UNREACH, CODE_PROTO_UNREACH);
        end
        // packet for some other router port
        for (int i = 0; i < nports; i++) begin
          if (w.dest_addr == port_addr[i])
            return icmp_word(ICMP_UNREACH, CODE_HOST_UNREACH);
        end
        // longest prefix match, later entry wins on equal mask
        for (int i = 0; i < nroutes; i++) begin
          if ((rt_mask[i] & w.dest_addr) == rt_prefix[i] && rt_mask[i] >= best_mask) begin
            found     = 1'b1;
            best      = i;
            best_mask = rt_mask[i];
          end
        end
        if (!found)
          return icmp_word(ICMP_UNREACH, CODE_NET_UNREACH);
        if (w.hop_limit <= TTL_MINIMUM)
          return icmp_word(ICMP_TIME_EXC, CODE_NONE);
        r.action        = ACT_FORWARD;
        r.out_port      = rt_port[best];
        r.next_hop      = (rt_gateway[best] != '0) ? rt_gateway[best] : w.dest_addr;
        r.out_hop_limit = w.hop_limit - 8'd1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] prefix_mask(int len);
    return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  // every field random, any kind
  function automatic in_word_t noise_word();
    logic [223:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t route_wr(int idx, logic [31:0] pfx, logic [31:0] msk,
                                        logic [31:0] gw, logic [1:0] prt);
    in_word_t w;
    w                = noise_word();
    w.kind           = KIND_ROUTE_WR;
    w.entry_index    = 4'(idx);
    w.new_prefix     = pfx;
    w.new_mask       = msk;
    w.new_gateway    = gw;
    w.new_route_port = prt;
    gen_prefix[idx]  = pfx;
    gen_mask[idx]    = msk;
    return w;
  endfunction

  function automatic in_word_t port_wr(int idx, logic [31:0] addr);
    in_word_t w;
    w               = noise_word();
    w.kind          = KIND_PORT_WR;
    w.entry_index   = 4'(idx);
    w.new_port_addr = addr;
    if (idx < PORTS) gen_port_addr[idx] = addr;
    return w;
  endfunction

  function automatic in_word_t header_word(logic [1:0] prt, logic [31:0] dst,
                                           logic [7:0] proto, logic [7:0] ttl,
                                           logic [7:0] icmp);
    in_word_t w;
    w           = noise_word();
    w.kind      = KIND_HEADER;
    w.in_port   = prt;
    w.dest_addr = dst;
    w.protocol  = proto;
    w.hop_limit = ttl;
    w.echo_kind = icmp;
    return w;
  endfunction

  // header aimed mostly at port addresses and existing routes
  function automatic in_word_t random_header();
    int          sel;
    int          k;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [7:0]  ttl;
    logic [7:0]  icmp;
    sel = $urandom_range(99);
    k   = $urandom_range(ROUTES - 1);
    if (sel < 15) dst = gen_port_addr[$urandom_range(PORTS - 1)];
    else if (sel < 75) dst = (gen_prefix[k] & gen_mask[k]) | (32'($urandom) & ~gen_mask[k]);
    else dst = $urandom;
    case ($urandom_range(5))
      0: proto = PROTO_TCP;
      1: proto = PROTO_UDP;
      2, 3: proto = PROTO_ICMP;
      default: proto = 8'($urandom);
    endcase
    case ($urandom_range(4))
      0: ttl = 8'd0;
      1: ttl = TTL_MINIMUM;
      2: ttl = 8'd2;
      default: ttl = 8'($urandom);
    endcase
    icmp = ($urandom_range(1) == 0) ? ICMP_ECHO_REQ : 8'($urandom);
    return header_word(2'($urandom_range(PORTS - 1)), dst, proto, ttl, icmp);
  endfunction

  function automatic in_word_t random_route_write();
    int          sel;
    logic [31:0] msk;
    logic [31:0] pfx;
    logic [31:0] gw;
    sel = $urandom_range(9);
    if (sel == 0) msk = $urandom;
    else if (sel == 1) msk = prefix_mask($urandom_range(7, 0));
    else msk = prefix_mask($urandom_range(32, 8));
    pfx = $urandom;
    if (sel != 9) pfx = pfx & msk;
    gw = ($urandom_range(2) == 0) ? 32'h0 : 32'($urandom);
    return route_wr($urandom_range(ROUTES - 1), pfx, msk, gw, 2'($urandom_range(3)));
  endfunction

  function automatic in_word_t random_port_write();
    int          idx;
    int          k;
    logic [31:0] addr;
    idx = ($urandom_range(7) == 0) ? $urandom_range(15, PORTS) : $urandom_range(PORTS - 1);
    k   = $urandom_range(ROUTES - 1);
    if ($urandom_range(1) == 0) addr = $urandom;
    else addr = gen_prefix[k] | (32'($urandom) & ~gen_mask[k]);
    return port_wr(idx, addr);
  endfunction

  function automatic in_word_t random_word();
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) return random_header();
    if (sel < 90) return random_route_write();
    if (sel < 96) return random_port_write();
    return noise_word();
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [4:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (word_q.size() != 0 || in_valid_i || decision_q.size() != 0) @(negedge clk_i);
  endtask

  // input driver: next word once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word_i  <= word_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and the long hold-off
  always @(negedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // monitor: check results, predict accepted words, track register writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (decision_q.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want_word = decision_q.pop_front();
          check_field("action", out_word_o.action, want_word.action);
          check_field("reply_type", out_word_o.reply_type, want_word.reply_type);
          check_field("reply_code", out_word_o.reply_code, want_word.reply_code);
          check_field("out_port", out_word_o.out_port, want_word.out_port);
          check_field("next_hop", out_word_o.next_hop, want_word.next_hop);
          check_field("out_hop_limit", out_word_o.out_hop_limit, want_word.out_hop_limit);
        end
      end
      in_took = in_valid_i && !in_stall_o;
      if (in_took) decision_q.push_back(decide_forwarding(in_word_i));
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_ROUTE_COUNT) route_cnt = cfg_data_i;
        else port_cnt = cfg_data_i[2:0];
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    int       i;
    int       p;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // table load with both counts at zero
    word_q.push_back(port_wr(0, 32'h0A00_0001));
    word_q.push_back(port_wr(1, 32'h0A00_0101));
    word_q.push_back(port_wr(2, 32'h0A00_0201));
    word_q.push_back(port_wr(3, 32'hFFFF_FFFF));
    word_q.push_back(port_wr(9, 32'h0A0A_0A07));
    word_q.push_back(route_wr(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 2'd0));
    word_q.push_back(route_wr(1, 32'h0A0A_0000, prefix_mask(16), 32'h0, 2'd1));
    word_q.push_back(route_wr(2, 32'h0A0A_0A00, prefix_mask(24), 32'h0A0A_0101, 2'd2));
    word_q.push_back(route_wr(3, 32'h0A0A_0A00, prefix_mask(24), 32'h0, 2'd3));
    word_q.push_back(route_wr(4, 32'h0A0A_0A05, prefix_mask(32), 32'hFFFF_FFFF, 2'd3));
    word_q.push_back(route_wr(5, 32'h8000_0000, 32'h8000_0000, 32'h0B00_0001, 2'd2));
    word_q.push_back(route_wr(6, 32'h0000_1234, 32'h0000_FFFF, 32'h0, 2'd1));
    for (i = 7; i < ROUTES; i++)
      word_q.push_back(route_wr(i, 32'hC0A8_0000 | (32'(i) << 8), prefix_mask(24),
                                $urandom, 2'(i)));
    w      = noise_word();
    w.kind = KIND_UNKNOWN;
    word_q.push_back(w);
    word_q.push_back(header_word(2'd0, 32'h0A00_0001, PROTO_TCP, 8'd64, 8'd0));
    wait_idle();

    // directed headers against the loaded tables
    write_reg(REG_ROUTE_COUNT, 5'd16);
    write_reg(REG_PORT_COUNT, 5'd4);
    word_q.push_back(header_word(2'd0, 32'h0A00_0001, PROTO_TCP, 8'd64, 8'd0));
    word_q.push_back(header_word(2'd1, 32'h0A00_0101, PROTO_UDP, 8'd64, 8'd0));
    word_q.push_back(header_word(2'd2, 32'h0A00_0201, PROTO_ICMP, TTL_MINIMUM,
                                 ICMP_ECHO_REQ));
    word_q.push_back(header_word(2'd3, 32'hFFFF_FFFF, PROTO_ICMP, 8'd255,
                                 ICMP_ECHO_REQ));
    word_q.push_back(header_word(2'd0, 32'h0A00_0001, PROTO_ICMP, 8'd64,
                                 ICMP_ECHO_RPL));
    word_q.push_back(header_word(2'd1, 32'h0A00_0101, PROTO_GRE, 8'd0, 8'd0));
    word_q.push_back(header_word(2'd0, 32'h0A00_0201, PROTO_TCP, 8'd64, 8'd0));
    word_q.push_back(header_word(2'd2, 32'h0A0A_0A07, PROTO_UDP, 8'd64, 8'd0));
    word_q.push_back(header_word(2'd3, 32'h0A0A_0B01, PROTO_TCP, 8'd2, 8'd0));
    word_q.push_back(header_word(2'd1, 32'h0A0A_0A05, PROTO_UDP, 8'd255, 8'd0));
    word_q.push_back(header_word(2'd1, 32'h0A0A_0A05, PROTO_UDP, TTL_MINIMUM, 8'd0));
    word_q.push_back(header_word(2'd1, 32'h0A0A_0A05, PROTO_UDP, 8'd0, 8'd0));
    word_q.push_back(header_word(2'd2, 32'h8000_1234, PROTO_ICMP, 8'd9, 8'd0));
    word_q.push_back(header_word(2'd0, 32'h0102_0304, PROTO_TCP, 8'd64, 8'd0));
    wait_idle();

    // random phases over count settings and idling modes
    for (p = 0; p < PHASES; p++) begin
      write_reg(REG_ROUTE_COUNT, 5'(route_set[p]));
      write_reg(REG_PORT_COUNT, 5'(port_set[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      for (i = 0; i < PHASE_WORDS; i++) word_q.push_back(random_word());
      if (p == 0 || p == 4) hold_reqs++;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/ifd_pkg.sv
src/ifd_route_cell.sv
src/ifd_port_table.sv
src/ipv4_forwarding_decision.sv
sim/tb_top.sv
